// ----- sv/dqa_pkg.sv -----
`timescale 1ns / 1ps
package dqa_pkg;
	localparam int FracBits = 24;
	localparam int CompW    = 32;
	localparam int ProdW    = 64;
	localparam int AccW     = 68;

	typedef enum logic [2:0] {
		OP_MUL    = 3'd0,
		OP_CJMUL  = 3'd1,
		OP_MULCJ  = 3'd2,
		OP_ADD    = 3'd3,
		OP_SUB    = 3'd4,
		OP_CONJ   = 3'd5
	} op_t;

	typedef logic signed [CompW-1:0] comp_t;
	typedef comp_t quat_t [4];

	// result sign/operand selection for one product term
	typedef struct packed {
		logic [1:0] ai;
		logic [1:0] bi;
		logic       neg;
	} term_t;

	// hamilton product terms for output component k, term j
	function automatic term_t hterm(input int k, input int j);
		term_t t;
		t = '0;
		case (k * 4 + j)
			0:  t = '{2'd3, 2'd0, 1'b0};
			1:  t = '{2'd0, 2'd3, 1'b0};
			2:  t = '{2'd1, 2'd2, 1'b0};
			3:  t = '{2'd2, 2'd1, 1'b1};
			4:  t = '{2'd3, 2'd1, 1'b0};
			5:  t = '{2'd0, 2'd2, 1'b1};
			6:  t = '{2'd1, 2'd3, 1'b0};
			7:  t = '{2'd2, 2'd0, 1'b0};
			8:  t = '{2'd3, 2'd2, 1'b0};
			9:  t = '{2'd0, 2'd1, 1'b0};
			10: t = '{2'd1, 2'd0, 1'b1};
			11: t = '{2'd2, 2'd3, 1'b0};
			12: t = '{2'd3, 2'd3, 1'b0};
			13: t = '{2'd0, 2'd0, 1'b1};
			14: t = '{2'd1, 2'd1, 1'b1};
			15: t = '{2'd2, 2'd2, 1'b1};
			default: t = '0;
		endcase
		return t;
	endfunction

	// saturate a wide signed value to 32 bits
	function automatic logic [CompW:0] sat_w(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] mx;
		logic signed [AccW-1:0] mn;
		mx = AccW'(32'sh7fffffff);
		mn = -(AccW'(64'sh80000000));
		if (v > mx) return {1'b1, 32'h7fffffff};
		if (v < mn) return {1'b1, 32'h80000000};
		return {1'b0, v[CompW-1:0]};
	endfunction
endpackage

// ----- sv/dqa_if.sv -----
`timescale 1ns / 1ps
interface dqa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [63:0] a_real_xy;
	logic [63:0] a_real_zw;
	logic [63:0] a_dual_xy;
	logic [63:0] a_dual_zw;
	logic [63:0] b_real_xy;
	logic [63:0] b_real_zw;
	logic [63:0] b_dual_xy;
	logic [63:0] b_dual_zw;
	modport source (output valid, req_type, a_real_xy, a_real_zw, a_dual_xy, a_dual_zw,
		b_real_xy, b_real_zw, b_dual_xy, b_dual_zw, input ready);
	modport sink (input valid, req_type, a_real_xy, a_real_zw, a_dual_xy, a_dual_zw,
		b_real_xy, b_real_zw, b_dual_xy, b_dual_zw, output ready);
endinterface

interface dqa_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] c_real_xy;
	logic [63:0] c_real_zw;
	logic [63:0] c_dual_xy;
	logic [63:0] c_dual_zw;
	logic        overflow;
	modport source (output valid, c_real_xy, c_real_zw, c_dual_xy, c_dual_zw, overflow,
		input ready);
	modport sink (input valid, c_real_xy, c_real_zw, c_dual_xy, c_dual_zw, overflow,
		output ready);
endinterface

// ----- sv/dual_quaternion_alu_unit.sv -----
`timescale 1ns / 1ps
// channel | modport | payload
// req     | sink    | req_type, a/b real/dual xy/zw
// rsp     | source  | c real/dual xy/zw, overflow
// one transaction per cycle sustained while rsp accepts results; a request passes through
// the operand prep, multiply, sum and round/saturate pipeline, then the output register.
// arst_n clears all valid bits; payload registers are not reset.
// a stall on rsp freezes the whole pipeline only when the output register is
// full and not taken; nothing is dropped or repeated.
module dual_quaternion_alu_unit (
	input  logic   clk,
	input  logic   arst_n,
	dqa_req_if.sink   req,
	dqa_rsp_if.source rsp
);
	import dqa_pkg::*;

	logic        en;
	logic        cv;
	logic [63:0] words [8];
	logic [63:0] cw [4];
	logic        covf;
	logic        ov_q;
	logic [63:0] ow_q [4];
	logic        oovf_q;

	assign en = !ov_q || rsp.ready;
	assign req.ready = en;
	assign words = '{req.a_real_xy, req.a_real_zw, req.a_dual_xy, req.a_dual_zw,
		req.b_real_xy, req.b_real_zw, req.b_dual_xy, req.b_dual_zw};

	dqa_core u_core (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(req.valid),
		.in_type(req.req_type), .in_words(words),
		.out_valid(cv), .out_words(cw), .out_ovf(covf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= cv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ow_q   <= cw;
			oovf_q <= covf;
		end
	end

	assign rsp.valid     = ov_q;
	assign rsp.c_real_xy = ow_q[0];
	assign rsp.c_real_zw = ow_q[1];
	assign rsp.c_dual_xy = ow_q[2];
	assign rsp.c_dual_zw = ow_q[3];
	assign rsp.overflow  = oovf_q;
endmodule

// ----- sv/dqa_core.sv -----
`timescale 1ns / 1ps
// four-stage datapath: s1 operand prep, s2 products, s3 sums, s4 round/saturate
module dqa_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [2:0]  in_type,
	input  logic [63:0] in_words [8],
	output logic        out_valid,
	output logic [63:0] out_words [4],
	output logic        out_ovf
);
	import dqa_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [2:0]  op_s1, op_s2, op_s3;
	comp_t       ar_s1 [4], ad_s1 [4], br_s1 [4], bd_s1 [4];
	// 48 products: real 16, dual 32
	logic signed [ProdW:0] pr_s2 [16];
	logic signed [ProdW:0] pd_s2 [32];
	// add/sub/conj results bypassing the multipliers
	logic [CompW:0] ls_s2 [8];
	logic [CompW:0] ls_s3 [8];
	logic signed [AccW-1:0] acc_s3 [8];
	logic [63:0] w_s4 [4];
	logic        ovf_s4;

	// stage 1: unpack operand components, conjugation is folded into stage 2 signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_type;
			for (int i = 0; i < 4; i++) begin
				ar_s1[i] <= comp_t'(in_words[i/2][32*(i%2) +: 32]);
				ad_s1[i] <= comp_t'(in_words[2+i/2][32*(i%2) +: 32]);
				br_s1[i] <= comp_t'(in_words[4+i/2][32*(i%2) +: 32]);
				bd_s1[i] <= comp_t'(in_words[6+i/2][32*(i%2) +: 32]);
			end
		end
	end

	// stage 2: products with conjugation folded into sign, and linear ops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		term_t t;
		logic  na, nb;
		logic signed [ProdW-1:0] p;
		logic signed [CompW+1:0] x;
		if (en) begin
			op_s2 <= op_s1;
			for (int k = 0; k < 4; k++) begin
				for (int j = 0; j < 4; j++) begin
					t  = hterm(k, j);
					na = (op_s1 == OP_CJMUL) && (t.ai != 2'd3);
					nb = (op_s1 == OP_MULCJ) && (t.bi != 2'd3);
					p = ar_s1[t.ai] * br_s1[t.bi];
					pr_s2[k*4+j] <= (t.neg ^ na ^ nb) ? -(ProdW+1)'(p) : (ProdW+1)'(p);
					p = ar_s1[t.ai] * bd_s1[t.bi];
					pd_s2[k*8+j] <= (t.neg ^ na ^ nb) ? -(ProdW+1)'(p) : (ProdW+1)'(p);
					p = ad_s1[t.ai] * br_s1[t.bi];
					pd_s2[k*8+4+j] <= (t.neg ^ na ^ nb) ? -(ProdW+1)'(p) : (ProdW+1)'(p);
				end
				x = '0;
				case (op_s1)
					OP_ADD:  x = (CompW+2)'(ar_s1[k]) + (CompW+2)'(br_s1[k]);
					OP_SUB:  x = (CompW+2)'(ar_s1[k]) - (CompW+2)'(br_s1[k]);
					OP_CONJ: x = (k == 3) ? (CompW+2)'(ar_s1[k]) : -(CompW+2)'(ar_s1[k]);
					default: x = '0;
				endcase
				ls_s2[k] <= sat_w(AccW'(x));
				case (op_s1)
					OP_ADD:  x = (CompW+2)'(ad_s1[k]) + (CompW+2)'(bd_s1[k]);
					OP_SUB:  x = (CompW+2)'(ad_s1[k]) - (CompW+2)'(bd_s1[k]);
					OP_CONJ: x = (k == 3) ? (CompW+2)'(ad_s1[k]) : -(CompW+2)'(ad_s1[k]);
					default: x = '0;
				endcase
				ls_s2[4+k] <= sat_w(AccW'(x));
			end
		end
	end

	// stage 3: sum product terms with rounding bias
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		logic signed [AccW-1:0] s;
		if (en) begin
			op_s3 <= op_s2;
			ls_s3 <= ls_s2;
			for (int k = 0; k < 4; k++) begin
				s = AccW'(1) <<< (FracBits - 1);
				for (int j = 0; j < 4; j++) s = s + AccW'(pr_s2[k*4+j]);
				acc_s3[k] <= s;
				s = AccW'(1) <<< (FracBits - 1);
				for (int j = 0; j < 8; j++) s = s + AccW'(pd_s2[k*8+j]);
				acc_s3[4+k] <= s;
			end
		end
	end

	// stage 4: shift, saturate, select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		logic [CompW:0] r [8];
		logic o;
		if (en) begin
			o = 1'b0;
			for (int i = 0; i < 8; i++) begin
				case (op_s3)
					OP_MUL, OP_CJMUL, OP_MULCJ: r[i] = sat_w(acc_s3[i] >>> FracBits);
					OP_ADD, OP_SUB, OP_CONJ:    r[i] = ls_s3[i];
					default:                    r[i] = '0;
				endcase
				o = o | r[i][CompW];
			end
			for (int i = 0; i < 4; i++) w_s4[i] <= {r[2*i+1][CompW-1:0], r[2*i][CompW-1:0]};
			ovf_s4 <= o;
		end
	end

	assign out_valid = v_s4;
	assign out_words = w_s4;
	assign out_ovf   = ovf_s4;
endmodule
